// ----- rtl/nlp_pkg.sv -----
// Shared types, constants and character helpers of the numeric literal parser.
package nlp_pkg;

   // Data widths.
   localparam int VALUE_WIDTH    = 64;
   localparam int EXPONENT_WIDTH = 16;
   localparam int WORK_WIDTH     = (VALUE_WIDTH > EXPONENT_WIDTH) ? VALUE_WIDTH : EXPONENT_WIDTH;
   localparam int RADIX_WIDTH    = 5;
   localparam int MAC_WIDTH      = WORK_WIDTH + RADIX_WIDTH;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_ZERODIV  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   // Radix values and digit markers.
   localparam logic [RADIX_WIDTH-1:0] RADIX_NONE      = 5'd0;
   localparam logic [RADIX_WIDTH-1:0] RADIX_TWO       = 5'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_EIGHT     = 5'd8;
   localparam logic [RADIX_WIDTH-1:0] RADIX_TEN       = 5'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_HEX_SPLIT = 5'd15;
   localparam logic [RADIX_WIDTH-1:0] RADIX_HEX       = 5'd16;
   localparam logic [RADIX_WIDTH-1:0] DIGIT_NONE      = 5'd16;
   localparam logic [RADIX_WIDTH-1:0] DIGIT_ZERO      = 5'd0;

   // ASCII characters of interest.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LF    = 8'h66;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_LE    = 8'h65;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UD    = 8'h44;
   localparam logic [7:0] CH_LD    = 8'h64;
   localparam logic [7:0] CH_UO    = 8'h4f;
   localparam logic [7:0] CH_LO    = 8'h6f;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_LB    = 8'h62;

   // Value of a hex digit character, or DIGIT_NONE for any other byte.
   function automatic logic [RADIX_WIDTH-1:0] digit_of(input logic [7:0] c);
      logic [RADIX_WIDTH-1:0] d;
      d = DIGIT_NONE;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         d = RADIX_WIDTH'(c - CH_ZERO);
      end else if (c inside {[CH_UA:CH_UF]}) begin
         d = RADIX_WIDTH'(c - CH_UA) + RADIX_TEN;
      end else if (c inside {[CH_LA:CH_LF]}) begin
         d = RADIX_WIDTH'(c - CH_LA) + RADIX_TEN;
      end
      return d;
   endfunction

   // Radix selected by a prefix letter, or RADIX_NONE.
   function automatic logic [RADIX_WIDTH-1:0] prefix_radix(input logic [7:0] c);
      logic [RADIX_WIDTH-1:0] r;
      case (c)
         CH_LX, CH_UX: r = RADIX_HEX;
         CH_LD, CH_UD: r = RADIX_TEN;
         CH_LO, CH_UO: r = RADIX_EIGHT;
         CH_LB, CH_UB: r = RADIX_TWO;
         default:      r = RADIX_NONE;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/nlp_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module nlp_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [nlp_pkg::VALUE_WIDTH-1:0]   dividend,
   input  logic [nlp_pkg::VALUE_WIDTH-1:0]   divisor,
   output logic                              done,
   output logic [nlp_pkg::VALUE_WIDTH-1:0]   quotient
);
   import nlp_pkg::*;

   localparam int CntW = $clog2(VALUE_WIDTH + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvs_ff, dvs_in;
   logic [VALUE_WIDTH:0]   rem_sh;
   logic [VALUE_WIDTH:0]   diff;

   // Shift in the next dividend bit and try a subtraction.
   assign rem_sh = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   // Step control and datapath.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(VALUE_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[VALUE_WIDTH] ? rem_sh[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/numeric_literal_parser.sv -----
// Numeric literal parser: at most one ASCII character per item, one result per literal.
// An item that is not last is accepted, then takes one multiply-add pass; a slash closes
// the numerator part instead. The last item adds a finish pass, the exponent loop (a
// multiply-add pass per step when scaling up, a division through the shared divider per
// step when scaling down), a division for a/b literals, and an output state; one item at a time.
// Synchronous reset clears all parser state; the state also returns to reset after each result.
module numeric_literal_parser (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_ch,
   input  logic                                  req_has_char,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [nlp_pkg::VALUE_WIDTH-1:0] rsp_value,
   output logic [1:0]                            rsp_status
);
   import nlp_pkg::*;

   localparam logic [VALUE_WIDTH-1:0]    VALUE_LIMIT = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [EXPONENT_WIDTH-1:0] EXP_LIMIT   = '1;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CHAR  = 9'b000000010,
      S_FIN   = 9'b000000100,
      S_EXP   = 9'b000001000,
      S_EXPW  = 9'b000010000,
      S_SLASH = 9'b000100000,
      S_END   = 9'b001000000,
      S_DIVW  = 9'b010000000,
      S_OUT   = 9'b100000000
   } seq_type;

   typedef enum logic [10:0] {
      PH_M_START    = 11'b00000000001,
      PH_M_ZERO     = 11'b00000000010,
      PH_M_PREFIXED = 11'b00000000100,
      PH_M_DIGITS   = 11'b00000001000,
      PH_M_HEXSEP   = 11'b00000010000,
      PH_X_SIGN1    = 11'b00000100000,
      PH_X_SIGN2    = 11'b00001000000,
      PH_X_START    = 11'b00010000000,
      PH_X_ZERO     = 11'b00100000000,
      PH_X_PREFIXED = 11'b01000000000,
      PH_X_DIGITS   = 11'b10000000000
   } phase_type;

   // Registers.
   seq_type                 seq_ff, seq_in;
   phase_type               phase_ff, phase_in;
   logic [RADIX_WIDTH-1:0]  radix_ff, radix_in;
   logic [RADIX_WIDTH-1:0]  exp_radix_ff, exp_radix_in;
   logic [VALUE_WIDTH-1:0]  acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0]  num_ff, num_in;
   logic [EXPONENT_WIDTH-1:0] exp_ff, exp_in;
   logic                    exp_neg_ff, exp_neg_in;
   logic [7:0]              held_ff, held_in;
   logic                    held_valid_ff, held_valid_in;
   logic                    frac_ff, frac_in;
   status_type              err_ff, err_in;
   logic                    div_pend_ff, div_pend_in;
   logic                    slash_ff, slash_in;
   logic [7:0]              ch_ff, ch_in;
   logic                    has_ff, has_in;
   logic                    last_ff, last_in;
   logic [VALUE_WIDTH-1:0]  res_ff, res_in;

   // Decode outputs.
   phase_type               f_phase;
   logic [RADIX_WIDTH-1:0]  f_radix, f_exp_radix;
   logic                    f_exp_neg, f_held_valid, f_frac;
   logic [7:0]              f_held;
   status_type              f_err;
   logic                    do_mant, do_exp, x_go;
   logic [RADIX_WIDTH-1:0]  pfx;
   logic                    tk_en, tk_exp, post_inv;
   logic [7:0]              tk_c;
   logic [RADIX_WIDTH-1:0]  tk_r, tk_d;

   // Shared multiply-add unit.
   logic [WORK_WIDTH-1:0]   mac_a;
   logic [MAC_WIDTH-1:0]    mac, mac_lim;
   logic                    mac_ovf;

   // Digit-take results.
   logic                    k_frac;
   status_type              k_err;
   logic [VALUE_WIDTH-1:0]  k_acc;
   logic [EXPONENT_WIDTH-1:0] k_exp;

   // Divider interface.
   logic                    div_start, div_done;
   logic [VALUE_WIDTH-1:0]  div_a, div_b, div_q;
   seq_type                 done_target, after_target;

   // Character decode: phase moves and which digit goes to the multiply-add unit.
   always_comb begin
      f_phase      = phase_ff;
      f_radix      = radix_ff;
      f_exp_radix  = exp_radix_ff;
      f_exp_neg    = exp_neg_ff;
      f_held       = held_ff;
      f_held_valid = held_valid_ff;
      f_frac       = frac_ff;
      f_err        = err_ff;
      do_mant      = 1'b0;
      do_exp       = 1'b0;
      x_go         = 1'b0;
      pfx          = RADIX_NONE;
      tk_en        = 1'b0;
      tk_exp       = 1'b0;
      tk_c         = ch_ff;
      tk_r         = radix_ff;
      tk_d         = DIGIT_ZERO;
      post_inv     = 1'b0;

      if (seq_ff == S_CHAR) begin
         pfx = prefix_radix(ch_ff);
         case (phase_ff)
            PH_M_START: begin
               if (ch_ff == CH_ZERO) begin
                  f_phase = PH_M_ZERO;
               end else begin
                  f_phase = PH_M_DIGITS;
                  do_mant = 1'b1;
               end
            end
            PH_M_ZERO: begin
               if (pfx != RADIX_NONE) begin
                  f_radix = pfx;
                  f_phase = PH_M_PREFIXED;
               end else begin
                  f_radix = (ch_ff == CH_DOT) ? RADIX_TEN : RADIX_EIGHT;
                  f_phase = PH_M_DIGITS;
                  do_mant = 1'b1;
               end
            end
            PH_M_PREFIXED, PH_M_DIGITS: begin
               f_phase = PH_M_DIGITS;
               do_mant = 1'b1;
            end
            PH_M_HEXSEP: begin
               f_held_valid = 1'b0;
               f_frac       = 1'b0;
               f_phase      = exp_neg_ff ? PH_X_START : PH_X_SIGN2;
               do_exp       = 1'b1;
            end
            default: begin
               do_exp = 1'b1;
            end
         endcase

         // Mantissa character: exponent separator, hex sign, held hex digit or plain digit.
         if (do_mant) begin
            if (f_radix < RADIX_HEX_SPLIT) begin
               if (ch_ff == CH_LE || ch_ff == CH_UE) begin
                  f_phase = PH_X_SIGN1;
                  f_frac  = 1'b0;
               end else begin
                  tk_en = 1'b1;
                  tk_c  = ch_ff;
                  tk_r  = f_radix;
                  tk_d  = digit_of(ch_ff);
               end
            end else if (ch_ff == CH_PLUS || ch_ff == CH_MINUS) begin
               if (!held_valid_ff) begin
                  f_err = ST_INVALID;
               end else begin
                  f_exp_neg = (ch_ff == CH_MINUS);
                  f_phase   = PH_M_HEXSEP;
               end
            end else begin
               if (held_valid_ff) begin
                  tk_en = 1'b1;
                  tk_c  = held_ff;
                  tk_r  = f_radix;
                  tk_d  = digit_of(held_ff);
               end
               f_held       = ch_ff;
               f_held_valid = 1'b1;
            end
         end

         // Exponent character: signs, optional prefix, then digits.
         if (do_exp) begin
            x_go = 1'b1;
            if (f_phase == PH_X_SIGN1) begin
               if (ch_ff == CH_PLUS) begin
                  f_phase = PH_X_SIGN2;
                  x_go    = 1'b0;
               end else if (ch_ff == CH_MINUS) begin
                  f_exp_neg = 1'b1;
                  f_phase   = PH_X_START;
                  x_go      = 1'b0;
               end else begin
                  f_phase = PH_X_START;
               end
            end else if (f_phase == PH_X_SIGN2) begin
               if (ch_ff == CH_MINUS) begin
                  f_exp_neg = 1'b1;
                  f_phase   = PH_X_START;
                  x_go      = 1'b0;
               end else begin
                  f_phase = PH_X_START;
               end
            end
            if (x_go) begin
               if (f_phase == PH_X_START) begin
                  if (ch_ff == CH_ZERO) begin
                     f_phase = PH_X_ZERO;
                     x_go    = 1'b0;
                  end else begin
                     f_exp_radix = RADIX_TEN;
                     f_phase     = PH_X_DIGITS;
                  end
               end else if (f_phase == PH_X_ZERO) begin
                  if (pfx != RADIX_NONE) begin
                     f_exp_radix = pfx;
                     f_phase     = PH_X_PREFIXED;
                     x_go        = 1'b0;
                  end else begin
                     f_exp_radix = (ch_ff == CH_DOT) ? RADIX_TEN : RADIX_EIGHT;
                     f_phase     = PH_X_DIGITS;
                  end
               end else begin
                  f_phase = PH_X_DIGITS;
               end
            end
            if (x_go) begin
               tk_en  = 1'b1;
               tk_exp = 1'b1;
               tk_c   = ch_ff;
               tk_r   = f_exp_radix;
               tk_d   = digit_of(ch_ff);
            end
         end
      end else if (seq_ff == S_FIN) begin
         // Close the part: bare prefix or dangling separator, then the held hex digit.
         if (phase_ff inside {PH_M_PREFIXED, PH_X_PREFIXED, PH_X_SIGN1}) begin
            f_err = ST_INVALID;
         end else if (phase_ff == PH_M_DIGITS && held_valid_ff) begin
            f_held_valid = 1'b0;
            tk_en        = 1'b1;
            tk_c         = held_ff;
            tk_d         = digit_of(held_ff);
         end else if (phase_ff == PH_M_HEXSEP) begin
            f_held_valid = 1'b0;
            tk_en        = 1'b1;
            tk_c         = held_ff;
            tk_d         = digit_of(held_ff);
            post_inv     = 1'b1;
         end
      end
   end

   // Multiply-add with range check: target * radix + digit against the limit.
   assign mac_a   = tk_exp ? WORK_WIDTH'(exp_ff) : WORK_WIDTH'(acc_ff);
   assign mac     = MAC_WIDTH'(mac_a) * MAC_WIDTH'(tk_r) + MAC_WIDTH'(tk_d);
   assign mac_lim = tk_exp ? MAC_WIDTH'(EXP_LIMIT) : MAC_WIDTH'(VALUE_LIMIT);
   assign mac_ovf = (mac > mac_lim);

   // Digit take: fraction point, range check, overflow, accumulate.
   always_comb begin
      k_frac = f_frac;
      k_err  = f_err;
      k_acc  = acc_ff;
      k_exp  = exp_ff;
      if (tk_en) begin
         if (tk_c == CH_DOT) begin
            if (f_frac) begin
               if (k_err == ST_OK) k_err = ST_INVALID;
            end else begin
               k_frac = 1'b1;
            end
         end else if (tk_d >= tk_r) begin
            if (k_err == ST_OK) k_err = ST_INVALID;
         end else if (!f_frac) begin
            if (mac_ovf) begin
               if (k_err == ST_OK) k_err = ST_OVERFLOW;
            end else if (tk_exp) begin
               k_exp = mac[EXPONENT_WIDTH-1:0];
            end else begin
               k_acc = mac[VALUE_WIDTH-1:0];
            end
         end
      end
      if (post_inv && k_err == ST_OK) k_err = ST_INVALID;
   end

   assign done_target  = slash_ff ? S_SLASH : S_END;
   assign after_target = last_ff ? S_FIN : S_IDLE;

   // Sequencer.
   always_comb begin
      seq_in        = seq_ff;
      phase_in      = phase_ff;
      radix_in      = radix_ff;
      exp_radix_in  = exp_radix_ff;
      acc_in        = acc_ff;
      num_in        = num_ff;
      exp_in        = exp_ff;
      exp_neg_in    = exp_neg_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      frac_in       = frac_ff;
      err_in        = err_ff;
      div_pend_in   = div_pend_ff;
      slash_in      = slash_ff;
      ch_in         = ch_ff;
      has_in        = has_ff;
      last_in       = last_ff;
      res_in        = res_ff;
      div_start     = 1'b0;
      div_a         = acc_ff;
      div_b         = VALUE_WIDTH'(radix_ff);

      case (seq_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in  = req_ch;
               has_in = req_has_char;
               last_in = req_last;
               seq_in = S_CHAR;
            end
         end
         S_CHAR: begin
            seq_in = after_target;
            if (has_ff && err_ff == ST_OK) begin
               if (ch_ff == CH_SLASH) begin
                  if (div_pend_ff) begin
                     err_in = ST_INVALID;
                  end else begin
                     slash_in = 1'b1;
                     seq_in   = S_FIN;
                  end
               end else begin
                  phase_in      = f_phase;
                  radix_in      = f_radix;
                  exp_radix_in  = f_exp_radix;
                  exp_neg_in    = f_exp_neg;
                  held_in       = f_held;
                  held_valid_in = f_held_valid;
                  frac_in       = k_frac;
                  err_in        = k_err;
                  acc_in        = k_acc;
                  exp_in        = k_exp;
               end
            end
         end
         S_FIN: begin
            if (err_ff != ST_OK) begin
               seq_in = done_target;
            end else begin
               held_valid_in = f_held_valid;
               frac_in       = k_frac;
               err_in        = k_err;
               acc_in        = k_acc;
               seq_in        = (k_err != ST_OK) ? done_target : S_EXP;
            end
         end
         S_EXP: begin
            // One exponent step per pass until the count or the value reaches zero or the value overflows.
            if (exp_ff == '0 || acc_ff == '0) begin
               seq_in = done_target;
            end else if (exp_neg_ff) begin
               div_start = 1'b1;
               seq_in    = S_EXPW;
            end else if (mac_ovf) begin
               err_in = ST_OVERFLOW;
               seq_in = done_target;
            end else begin
               acc_in = mac[VALUE_WIDTH-1:0];
               exp_in = exp_ff - EXPONENT_WIDTH'(1);
            end
         end
         S_EXPW: begin
            if (div_done) begin
               acc_in = div_q;
               exp_in = exp_ff - EXPONENT_WIDTH'(1);
               seq_in = S_EXP;
            end
         end
         S_SLASH: begin
            // Keep the numerator and start the divisor part.
            num_in        = acc_ff;
            div_pend_in   = 1'b1;
            slash_in      = 1'b0;
            phase_in      = PH_M_START;
            radix_in      = RADIX_TEN;
            exp_radix_in  = RADIX_TEN;
            acc_in        = '0;
            exp_in        = '0;
            exp_neg_in    = 1'b0;
            held_in       = '0;
            held_valid_in = 1'b0;
            frac_in       = 1'b0;
            seq_in        = after_target;
         end
         S_END: begin
            res_in = acc_ff;
            seq_in = S_OUT;
            if (div_pend_ff && err_ff == ST_OK) begin
               if (acc_ff == '0) begin
                  err_in = ST_ZERODIV;
               end else begin
                  div_start = 1'b1;
                  div_a     = num_ff;
                  div_b     = acc_ff;
                  seq_in    = S_DIVW;
               end
            end
         end
         S_DIVW: begin
            if (div_done) begin
               res_in = div_q;
               seq_in = S_OUT;
            end
         end
         S_OUT: begin
            // Result taken: back to the reset state.
            if (!rsp_stall) begin
               seq_in        = S_IDLE;
               phase_in      = PH_M_START;
               radix_in      = RADIX_TEN;
               exp_radix_in  = RADIX_TEN;
               acc_in        = '0;
               num_in        = '0;
               exp_in        = '0;
               exp_neg_in    = 1'b0;
               held_in       = '0;
               held_valid_in = 1'b0;
               frac_in       = 1'b0;
               err_in        = ST_OK;
               div_pend_in   = 1'b0;
               slash_in      = 1'b0;
            end
         end
         default: begin
            seq_in = S_IDLE;
         end
      endcase
   end

   // Control and parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= S_IDLE;
         phase_ff      <= PH_M_START;
         radix_ff      <= RADIX_TEN;
         exp_radix_ff  <= RADIX_TEN;
         acc_ff        <= '0;
         num_ff        <= '0;
         exp_ff        <= '0;
         exp_neg_ff    <= 1'b0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         frac_ff       <= 1'b0;
         err_ff        <= ST_OK;
         div_pend_ff   <= 1'b0;
         slash_ff      <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         radix_ff      <= radix_in;
         exp_radix_ff  <= exp_radix_in;
         acc_ff        <= acc_in;
         num_ff        <= num_in;
         exp_ff        <= exp_in;
         exp_neg_ff    <= exp_neg_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         frac_ff       <= frac_in;
         err_ff        <= err_in;
         div_pend_ff   <= div_pend_in;
         slash_ff      <= slash_in;
      end
   end

   // Captured item and result registers.
   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      has_ff  <= has_in;
      last_ff <= last_in;
      res_ff  <= res_in;
   end

   // Shared divider for downward exponent steps and the final a/b division.
   nlp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quotient (div_q)
   );

   // Ports.
   assign req_stall  = (seq_ff != S_IDLE);
   assign rsp_valid  = (seq_ff == S_OUT);
   assign rsp_value  = (err_ff == ST_OK) ? res_ff : '0;
   assign rsp_status = err_ff;

endmodule

// ----- rtl/nlp_checker.sv -----
// Port-level checks of the numeric literal parser and their bind.
module nlp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [nlp_pkg::VALUE_WIDTH-1:0] rsp_value,
   input logic [1:0]                      rsp_status
);
   import nlp_pkg::*;

   // An accepted item keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted on consecutive cycles");

   // No item is taken while a result waits.
   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result is pending");

   // An error result carries a zero value.
   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
      else $error("error result with nonzero value");

   // A stalled result holds.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("stalled result changed");

   // No repeated result: a taken result is not shown again.
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result repeated");

endmodule

bind numeric_literal_parser nlp_checker u_nlp_checker (.*);

// ----- sim/numeric_literal_parser_checker.sv -----
// Checker for the numeric literal parser: predicts every result and compares it.
module numeric_literal_parser_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic [7:0]                             req_ch,
   input  logic                                   req_has_char,
   input  logic                                   req_last,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [nlp_pkg::VALUE_WIDTH-1:0] rsp_value,
   input  logic [1:0]                             rsp_status,
   output int                                     fail_count,
   output int                                     result_count,
   output int                                     pending
);
   import nlp_pkg::*;

   typedef enum int {
      PH_M_START, PH_M_ZERO, PH_M_PREFIXED, PH_M_DIGITS, PH_M_HEXSEP,
      PH_X_SIGN1, PH_X_SIGN2, PH_X_START, PH_X_ZERO, PH_X_PREFIXED, PH_X_DIGITS
   } parse_phase_type;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      status_type                    status;
   } literal_result_type;

   localparam longint unsigned VALUE_MAX    = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam longint unsigned EXPONENT_MAX = (64'd1 << EXPONENT_WIDTH) - 64'd1;

   literal_result_type expected_results[$];

   // Parser state of the prediction.
   parse_phase_type phase;
   int unsigned     radix;
   int unsigned     exp_radix;
   longint unsigned accumulator;
   longint unsigned numerator;
   longint unsigned exponent;
   bit              exponent_negative;
   logic [7:0]      held_char;
   bit              held_valid;
   bit              fraction_seen;
   status_type      error_code;
   bit              divide_pending;

   function automatic void note_error(input status_type code);
      if (error_code == ST_OK) error_code = code;
   endfunction

   function automatic void restart_part();
      phase = PH_M_START;
      radix = 10;
      exp_radix = 10;
      accumulator = 0;
      exponent = 0;
      exponent_negative = 0;
      held_char = 8'd0;
      held_valid = 0;
      fraction_seen = 0;
   endfunction

   function automatic void clear_literal();
      restart_part();
      numerator = 0;
      divide_pending = 0;
      error_code = ST_OK;
   endfunction

   // Digit weight of a character; 16 stands for no digit at all.
   function automatic int unsigned weight_of(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
      if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
      if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
      return 16;
   endfunction

   function automatic int unsigned radix_of_letter(input logic [7:0] c);
      case (c)
         CH_LX, CH_UX: return 16;
         CH_LD, CH_UD: return 10;
         CH_LO, CH_UO: return 8;
         CH_LB, CH_UB: return 2;
         default:      return 0;
      endcase
   endfunction

   // One digit or point into a running number, with overflow check.
   function automatic void accumulate(input logic [7:0] c, input int unsigned r,
                                      inout longint unsigned total,
                                      input longint unsigned lim);
      int unsigned d;
      if (c == CH_DOT) begin
         if (fraction_seen) note_error(ST_INVALID);
         else fraction_seen = 1;
         return;
      end
      d = weight_of(c);
      if (d >= r) begin
         note_error(ST_INVALID);
         return;
      end
      if (fraction_seen) return;
      if (total > (lim - d) / r) begin
         note_error(ST_OVERFLOW);
         return;
      end
      total = total * r + d;
   endfunction

   function automatic void mantissa_char(input logic [7:0] c);
      longint unsigned acc;
      acc = accumulator;
      if (radix < 15) begin
         if (c == CH_LE || c == CH_UE) begin
            phase = PH_X_SIGN1;
            fraction_seen = 0;
            return;
         end
         accumulate(c, radix, acc, VALUE_MAX);
         accumulator = acc;
         return;
      end
      // In hex a sign splits off the exponent and the character before it is lost.
      if (c == CH_PLUS || c == CH_MINUS) begin
         if (!held_valid) begin
            note_error(ST_INVALID);
            return;
         end
         exponent_negative = (c == CH_MINUS);
         phase = PH_M_HEXSEP;
         return;
      end
      if (held_valid) accumulate(held_char, radix, acc, VALUE_MAX);
      accumulator = acc;
      held_char = c;
      held_valid = 1;
   endfunction

   function automatic void exponent_char(input logic [7:0] c);
      int unsigned     p;
      longint unsigned ex;
      if (phase == PH_X_SIGN1) begin
         if (c == CH_PLUS) begin
            phase = PH_X_SIGN2;
            return;
         end
         if (c == CH_MINUS) begin
            exponent_negative = 1;
            phase = PH_X_START;
            return;
         end
         phase = PH_X_START;
      end else if (phase == PH_X_SIGN2) begin
         if (c == CH_MINUS) begin
            exponent_negative = 1;
            phase = PH_X_START;
            return;
         end
         phase = PH_X_START;
      end
      if (phase == PH_X_START) begin
         if (c == CH_ZERO) begin
            phase = PH_X_ZERO;
            return;
         end
         exp_radix = 10;
         phase = PH_X_DIGITS;
      end else if (phase == PH_X_ZERO) begin
         p = radix_of_letter(c);
         if (p != 0) begin
            exp_radix = p;
            phase = PH_X_PREFIXED;
            return;
         end
         exp_radix = (c == CH_DOT) ? 10 : 8;
         phase = PH_X_DIGITS;
      end else begin
         phase = PH_X_DIGITS;
      end
      ex = exponent;
      accumulate(c, exp_radix, ex, EXPONENT_MAX);
      exponent = ex;
   endfunction

   function automatic void parse_char(input logic [7:0] c);
      int unsigned p;
      case (phase)
         PH_M_START: begin
            if (c == CH_ZERO) begin
               phase = PH_M_ZERO;
            end else begin
               phase = PH_M_DIGITS;
               mantissa_char(c);
            end
         end
         PH_M_ZERO: begin
            p = radix_of_letter(c);
            if (p != 0) begin
               radix = p;
               phase = PH_M_PREFIXED;
            end else begin
               radix = (c == CH_DOT) ? 10 : 8;
               phase = PH_M_DIGITS;
               mantissa_char(c);
            end
         end
         PH_M_PREFIXED, PH_M_DIGITS: begin
            phase = PH_M_DIGITS;
            mantissa_char(c);
         end
         PH_M_HEXSEP: begin
            held_valid = 0;
            fraction_seen = 0;
            phase = exponent_negative ? PH_X_START : PH_X_SIGN2;
            exponent_char(c);
         end
         default: exponent_char(c);
      endcase
   endfunction

   // Closes a part: flushes the held hex digit and applies the exponent.
   function automatic void close_part();
      longint unsigned steps;
      longint unsigned acc;
      if (error_code != ST_OK) return;
      if (phase == PH_M_PREFIXED || phase == PH_X_PREFIXED || phase == PH_X_SIGN1) begin
         note_error(ST_INVALID);
         return;
      end
      acc = accumulator;
      if (phase == PH_M_DIGITS && held_valid) begin
         held_valid = 0;
         accumulate(held_char, radix, acc, VALUE_MAX);
      end else if (phase == PH_M_HEXSEP) begin
         held_valid = 0;
         accumulate(held_char, radix, acc, VALUE_MAX);
         note_error(ST_INVALID);
      end
      accumulator = acc;
      if (error_code != ST_OK) return;
      steps = exponent;
      while (steps != 0 && accumulator != 0) begin
         if (exponent_negative) begin
            accumulator = accumulator / radix;
         end else begin
            if (accumulator > VALUE_MAX / radix) begin
               note_error(ST_OVERFLOW);
               return;
            end
            accumulator = accumulator * radix;
         end
         steps--;
      end
   endfunction

   // Applies one accepted item; queues a result when the item ends a literal.
   function automatic void apply_item(input logic [7:0] c, input bit has, input bit fin);
      literal_result_type r;
      longint unsigned    v;
      if (has && error_code == ST_OK) begin
         if (c == CH_SLASH) begin
            if (divide_pending) begin
               note_error(ST_INVALID);
            end else begin
               close_part();
               numerator = accumulator;
               divide_pending = 1;
               restart_part();
            end
         end else begin
            parse_char(c);
         end
      end
      if (!fin) return;
      close_part();
      v = accumulator;
      if (divide_pending && error_code == ST_OK) begin
         if (v == 0) note_error(ST_ZERODIV);
         else v = numerator / v;
      end
      r.value = (error_code == ST_OK) ? v : '0;
      r.status = error_code;
      expected_results.push_back(r);
      clear_literal();
   endfunction

   // Compare results first, then predict from the item taken on the same edge.
   always @(posedge clock) begin
      literal_result_type want;
      if (reset) begin
         clear_literal();
         expected_results.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
               $error("unexpected result: value %0d status %0d", rsp_value, rsp_status);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) apply_item(req_ch, req_has_char, req_last);
      end
      pending = expected_results.size();
   end

endmodule

// ----- sim/numeric_literal_parser_tb.sv -----
// Testbench top of the numeric literal parser: stimulus, flow control and verdict.
module numeric_literal_parser_tb;
   import nlp_pkg::*;

   localparam int ITEM_TARGET = 700;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD   = 400;

   typedef logic [7:0] char_queue_type[$];

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [7:0]                    req_ch = 8'd0;
   logic                          req_has_char = 1'b0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_value;
   logic [1:0]                    rsp_status;

   int fail_count;
   int result_count;
   int pending;
   int items_sent = 0;
   int literals_sent = 0;
   int sender_idle_pct = 28;
   int receiver_idle_pct = 75;
   int quiet_cycles = 0;

   numeric_literal_parser dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_ch(req_ch),
      .req_has_char(req_has_char), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   numeric_literal_parser_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_ch(req_ch),
      .req_has_char(req_has_char), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_value(rsp_value), .rsp_status(rsp_status),
      .fail_count(fail_count), .result_count(result_count), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver flow control, with one long hold-off once the run is under way.
   always @(negedge clock) begin
      int  hold_left;
      bit  held_once;
      if (!held_once && items_sent > 480) begin
         held_once = 1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("numeric_literal_parser_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one item; entered and left at a falling edge.
   task automatic offer_item(input logic [7:0] c, input bit has, input bit fin);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ch <= c;
      req_has_char <= has;
      req_last <= fin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
      if (items_sent == ITEM_TARGET / 3) begin
         sender_idle_pct = 75;
         receiver_idle_pct = 28;
      end else if (items_sent == 2 * ITEM_TARGET / 3) begin
         sender_idle_pct = 0;
         receiver_idle_pct = 0;
      end
   endtask

   // Sends a literal, with ignored items mixed in and sometimes an empty closing item.
   task automatic send_literal(input char_queue_type s);
      bit close_empty;
      close_empty = (s.size() == 0) || ($urandom_range(9) == 0);
      foreach (s[i]) begin
         if ($urandom_range(19) == 0) offer_item(8'($urandom), 1'b0, 1'b0);
         offer_item(s[i], 1'b1, !close_empty && (i == s.size() - 1));
      end
      if (close_empty) offer_item(8'($urandom), 1'b0, 1'b1);
      literals_sent++;
   endtask

   function automatic char_queue_type from_text(input string t);
      char_queue_type q;
      for (int i = 0; i < t.len(); i++) q.push_back(t[i]);
      return q;
   endfunction

   function automatic logic [7:0] digit_char(input int unsigned r);
      int unsigned d;
      d = $urandom_range(r - 1);
      if (d < 10) return 8'(CH_ZERO + d);
      return 8'(($urandom_range(1) ? CH_LA : CH_UA) + d - 10);
   endfunction

   // A mostly well-formed part with random content: prefix, digits, fraction, exponent.
   function automatic char_queue_type random_part();
      char_queue_type q;
      int unsigned    r;
      int unsigned    n;
      bit             upper;
      upper = $urandom_range(1);
      case ($urandom_range(5))
         0: r = 10;
         1: begin r = 16; q = {CH_ZERO, upper ? CH_UX : CH_LX}; end
         2: begin r = 10; q = {CH_ZERO, upper ? CH_UD : CH_LD}; end
         3: begin r = 8;  q = {CH_ZERO, upper ? CH_UO : CH_LO}; end
         4: begin r = 2;  q = {CH_ZERO, upper ? CH_UB : CH_LB}; end
         default: begin r = 8; q = {CH_ZERO}; end
      endcase
      n = ($urandom_range(7) == 0) ? $urandom_range(30, 12) : $urandom_range(6, 1);
      repeat (n) q.push_back(digit_char(r));
      if ($urandom_range(5) == 0) begin
         q.push_back(CH_DOT);
         repeat ($urandom_range(3)) q.push_back(digit_char(r));
      end
      if ($urandom_range(9) < 3) begin
         if (r < 15) begin
            q.push_back($urandom_range(1) ? CH_UE : CH_LE);
            if ($urandom_range(1)) q.push_back(CH_PLUS);
            if ($urandom_range(1)) q.push_back(CH_MINUS);
         end else begin
            q.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
         end
         if ($urandom_range(7) == 0) q.push_back(CH_ZERO);
         repeat ($urandom_range(2)) q.push_back(digit_char(10));
      end
      return q;
   endfunction

   // Most literals are well formed; some get a stray byte or are pure noise.
   function automatic char_queue_type random_literal();
      char_queue_type q;
      if ($urandom_range(19) == 0) begin
         repeat ($urandom_range(5, 1)) q.push_back(8'($urandom));
         return q;
      end
      q = random_part();
      if ($urandom_range(3) == 0) begin
         q.push_back(CH_SLASH);
         q = {q, random_part()};
      end
      if ($urandom_range(9) == 0) q[$urandom_range(q.size() - 1)] = 8'($urandom);
      return q;
   endfunction

   initial begin
      string directed[$];
      directed = {"", "0", "9223372036854775807", "9223372036854775808",
                  "0x7fffffffffffffff", "0X", "0d", "0O", "0b", "0B101", "017", "0.5",
                  "1.2.3", "12e", "12e+-2", "12E-1", "0x1F+2", "0x+1", "0xA-1",
                  "1e99", "0e70000", "12/5", "7/0", "1/2/3", "1e+0x10", "0xff/3"};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) send_literal(from_text(directed[i]));
      while (items_sent < ITEM_TARGET) send_literal(random_literal());
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d items forming %0d literals; checked %0d results.",
               items_sent, literals_sent, result_count);
      $display("Covered all prefixes, fractions, exponents, division and error cases.");
      if (fail_count == 0) begin
         $display("numeric_literal_parser_tb OK");
      end else begin
         $display("numeric_literal_parser_tb NOT OK");
      end
      $finish;
   end

endmodule
